### hw/rtl/mmb_pkg.sv
// mmb_pkg: shared types and command codes for the int8 matrix multiply with bias.
// Used by the controller, the datapath, the top level and the checker. No dependencies.
`timescale 1ns / 1ps

package mmb_pkg;

	// Command codes carried in cmd_t.command
	localparam logic [2:0] CMD_LOAD_A    = 3'd0;
	localparam logic [2:0] CMD_LOAD_B    = 3'd1;
	localparam logic [2:0] CMD_LOAD_BIAS = 3'd2;
	localparam logic [2:0] CMD_COMPUTE   = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;

	// One command transaction
	typedef struct packed {
		logic [2:0]         command;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [7:0]  elem_value;
		logic signed [31:0] bias_value;
	} cmd_t;

	// One response transaction
	typedef struct packed {
		logic signed [31:0] result_value;
		logic [3:0]         result_row;
		logic [3:0]         result_col;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_en;
		logic mac_en;
		logic wr_act;
		logic wr_wgt;
		logic wr_bias;
		logic rd_res;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic mac_last;
		logic pipe_busy;
		logic rd_room;
	} sts_t;

endpackage

### hw/rtl/mmb_ram.sv
// mmb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/mmb_ctrl.sv
// mmb_ctrl: controller state machine, command handshake and decode.
// Depends on mmb_pkg.
`timescale 1ns / 1ps

module mmb_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  logic [2:0]   command,
	input  mmb_pkg::sts_t sts,
	output mmb_pkg::ctl_t ctl
);
	import mmb_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_MAC   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign cmd_ready = (state_q == ST_IDLE) && sts.rd_room;
	assign accept    = cmd_valid && cmd_ready;

	always_comb begin
		ctl          = '0;
		ctl.clear_en = (state_q == ST_CLEAR);
		ctl.mac_en   = (state_q == ST_MAC);
		ctl.wr_act   = accept && (command == CMD_LOAD_A);
		ctl.wr_wgt   = accept && (command == CMD_LOAD_B);
		ctl.wr_bias  = accept && (command == CMD_LOAD_BIAS);
		ctl.rd_res   = accept && (command == CMD_READ);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && (command == CMD_COMPUTE)) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (sts.mac_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/mmb_datapath.sv
// mmb_datapath: operand and result memories, MAC pipeline, clear sweep and read path.
// Depends on mmb_pkg and mmb_ram.
`timescale 1ns / 1ps

module mmb_datapath #(
	parameter int DIM = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mmb_pkg::ctl_t ctl,
	output mmb_pkg::sts_t sts,
	input  mmb_pkg::cmd_t cmd_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mmb_pkg::rsp_t rsp_data
);
	import mmb_pkg::*;

	localparam int IW = $clog2(DIM);
	localparam int AW = $clog2(DIM * DIM);

	// index decode of the incoming transaction
	logic          row_ok;
	logic          col_ok;
	logic          elem_ok;
	logic [IW-1:0] col_idx;
	logic [AW-1:0] elem_addr;

	// clear sweep
	logic [AW-1:0] clr_q;
	logic          clr_last;
	logic          bias_clr_hit;

	// MAC loop counters
	logic [IW-1:0] r_q;
	logic [IW-1:0] c_q;
	logic [IW-1:0] k_q;
	logic          k_last;
	logic          c_last;
	logic          r_last;
	logic [AW-1:0] a_addr;
	logic [AW-1:0] b_addr;
	logic [AW-1:0] c_addr;

	// memory read data
	logic [7:0]  a_rdata;
	logic [7:0]  b_rdata;
	logic [31:0] bias_rdata;
	logic [31:0] res_rdata;

	// MAC pipeline
	logic               mv_s1;
	logic               first_s1;
	logic               last_s1;
	logic [AW-1:0]      addr_s1;
	logic               mv_s2;
	logic               first_s2;
	logic               last_s2;
	logic [AW-1:0]      addr_s2;
	logic signed [15:0] prod_s2;
	logic [31:0]        bias_s2;
	logic               wr_s3;
	logic [AW-1:0]      addr_s3;
	logic [31:0]        bias_s3;
	logic [31:0]        acc_q;
	logic [31:0]        prod_ext;

	// read path
	logic       rd_s1;
	logic       rd_ok_s1;
	logic [3:0] rd_row_s1;
	logic [3:0] rd_col_s1;
	logic       rd_adv;
	logic       out_valid_q;
	rsp_t       out_q;

	// memory ports
	logic          act_we;
	logic          wgt_we;
	logic [AW-1:0] ab_waddr;
	logic [7:0]    ab_wdata;
	logic          bias_we;
	logic [IW-1:0] bias_waddr;
	logic [31:0]   bias_wdata;
	logic          res_we;
	logic [AW-1:0] res_waddr;
	logic [31:0]   res_wdata;

	assign row_ok    = 32'(cmd_data.row) < DIM;
	assign col_ok    = 32'(cmd_data.col) < DIM;
	assign elem_ok   = row_ok && col_ok;
	assign col_idx   = IW'(cmd_data.col);
	assign elem_addr = AW'(cmd_data.row) * AW'(DIM) + AW'(cmd_data.col);

	// Clear sweep: one entry of each store per cycle while clearing (bias: first DIM only)
	assign clr_last     = (clr_q == AW'(DIM * DIM - 1));
	assign bias_clr_hit = 32'(clr_q) < DIM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear_en) begin
			clr_q <= clr_last ? '0 : clr_q + 1'b1;
		end
	end

	// MAC loop: k innermost, then column, then row
	assign k_last = (k_q == IW'(DIM - 1));
	assign c_last = (c_q == IW'(DIM - 1));
	assign r_last = (r_q == IW'(DIM - 1));
	assign a_addr = AW'(r_q) * AW'(DIM) + AW'(k_q);
	assign b_addr = AW'(k_q) * AW'(DIM) + AW'(c_q);
	assign c_addr = AW'(r_q) * AW'(DIM) + AW'(c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else if (ctl.mac_en) begin
			if (k_last) begin
				k_q <= '0;
				if (c_last) begin
					c_q <= '0;
					r_q <= r_last ? '0 : r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Memories
	assign act_we   = ctl.clear_en || (ctl.wr_act && elem_ok);
	assign wgt_we   = ctl.clear_en || (ctl.wr_wgt && elem_ok);
	assign ab_waddr = ctl.clear_en ? clr_q : elem_addr;
	assign ab_wdata = ctl.clear_en ? 8'd0 : cmd_data.elem_value;

	assign bias_we    = ctl.clear_en ? bias_clr_hit : (ctl.wr_bias && col_ok);
	assign bias_waddr = ctl.clear_en ? clr_q[IW-1:0] : col_idx;
	assign bias_wdata = ctl.clear_en ? 32'd0 : cmd_data.bias_value;

	assign res_we    = ctl.clear_en || wr_s3;
	assign res_waddr = ctl.clear_en ? clr_q : addr_s3;
	assign res_wdata = ctl.clear_en ? 32'd0 : acc_q + bias_s3;

	mmb_ram #(.WIDTH(8), .DEPTH(DIM * DIM)) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (ab_waddr),
		.wdata (ab_wdata),
		.re    (ctl.mac_en),
		.raddr (a_addr),
		.rdata (a_rdata)
	);

	mmb_ram #(.WIDTH(8), .DEPTH(DIM * DIM)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (ab_waddr),
		.wdata (ab_wdata),
		.re    (ctl.mac_en),
		.raddr (b_addr),
		.rdata (b_rdata)
	);

	mmb_ram #(.WIDTH(32), .DEPTH(DIM)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (bias_waddr),
		.wdata (bias_wdata),
		.re    (ctl.mac_en),
		.raddr (c_q),
		.rdata (bias_rdata)
	);

	mmb_ram #(.WIDTH(32), .DEPTH(DIM * DIM)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.re    (ctl.rd_res),
		.raddr (elem_addr),
		.rdata (res_rdata)
	);

	// MAC pipeline: s1 operands, s2 product, s3 accumulate, then write back with bias
	assign prod_ext = {{16{prod_s2[15]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
			mv_s2 <= 1'b0;
			wr_s3 <= 1'b0;
		end else begin
			mv_s1 <= ctl.mac_en;
			mv_s2 <= mv_s1;
			wr_s3 <= mv_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= k_last;
		addr_s1  <= c_addr;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		addr_s2  <= addr_s1;
		prod_s2  <= $signed(a_rdata) * $signed(b_rdata);
		bias_s2  <= bias_rdata;
		addr_s3  <= addr_s2;
		bias_s3  <= bias_s2;
		if (mv_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
	end

	// Read path: memory read stage, then output register
	assign rd_adv = rd_s1 && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.rd_res) begin
				rd_s1 <= 1'b1;
			end else if (rd_adv) begin
				rd_s1 <= 1'b0;
			end
			if (rd_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_res) begin
			rd_ok_s1  <= elem_ok;
			rd_row_s1 <= cmd_data.row;
			rd_col_s1 <= cmd_data.col;
		end
		if (rd_adv) begin
			out_q.result_value <= rd_ok_s1 ? res_rdata : 32'd0;
			out_q.result_row   <= rd_row_s1;
			out_q.result_col   <= rd_col_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	always_comb begin
		sts            = '0;
		sts.clear_last = clr_last;
		sts.mac_last   = k_last && c_last && r_last;
		sts.pipe_busy  = mv_s1 || mv_s2 || wr_s3;
		sts.rd_room    = !rd_s1 || rd_adv;
	end

endmodule

### hw/rtl/int8_matrix_multiply_bias.sv
// int8_matrix_multiply_bias: top level, DIM x DIM int8 matrix multiply with column bias.
// Depends on mmb_pkg, mmb_ctrl, mmb_datapath (and mmb_ram through it).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  cmd     | in        | cmd_valid, cmd_ready | cmd_data: command,row,col,values
//  rsp     | out       | rsp_valid, rsp_ready | rsp_data: result_value,row,col
//
// Commands: load A, load B, load bias and unused codes stream back to back while no
// read is held in the memory read stage. A read's response passes through the memory
// read stage into the output register. Compute runs on the single MAC (one A and
// one B memory read a cycle), then drains the MAC pipeline stages s1, s2 and s3.
// Reset: a clearing pass over DIM*DIM entries zeroes every store; cmd_ready stays low.
// Stalls: one read may wait in the memory read stage behind a held response.
`timescale 1ns / 1ps

module int8_matrix_multiply_bias #(
	parameter int DIM = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  mmb_pkg::cmd_t cmd_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mmb_pkg::rsp_t rsp_data
);
	import mmb_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequencing: clear sweep, command decode, MAC run and drain
	mmb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (cmd_data.command),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Stores, MAC pipeline and response register
	mmb_datapath #(.DIM(DIM)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

### hw/rtl/mmb_checker.sv
// mmb_checker: port-level assertions for int8_matrix_multiply_bias, attached by bind.
// Depends on mmb_pkg.
`timescale 1ns / 1ps

module mmb_checker #(
	parameter int DIM = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input mmb_pkg::cmd_t cmd_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input mmb_pkg::rsp_t rsp_data
);
	import mmb_pkg::*;

	logic rd_acc;
	logic comp_acc;

	assign rd_acc   = cmd_valid && cmd_ready && (cmd_data.command == CMD_READ);
	assign comp_acc = cmd_valid && cmd_ready && (cmd_data.command == CMD_COMPUTE);

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed while stalled");

	// a response only appears after a read transaction
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(rd_acc, 2))
		else $error("response without a read");

	// echo the read coordinates
	a_rsp_echo: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> rsp_data.result_row == $past(cmd_data.row, 2) &&
			rsp_data.result_col == $past(cmd_data.col, 2))
		else $error("response coordinates do not match the read");

	// out-of-range reads return zero
	a_rsp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (32'(rsp_data.result_row) >= DIM || 32'(rsp_data.result_col) >= DIM)
			|-> rsp_data.result_value == 32'sd0)
		else $error("out-of-range read returned non-zero");

	// compute blocks further commands
	a_comp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		comp_acc |=> !cmd_ready)
		else $error("command accepted while computing");

endmodule

bind int8_matrix_multiply_bias mmb_checker #(.DIM(DIM)) u_mmb_checker (.*);
